// ===== hw/rtl/sirk_pkg.sv =====
// -----------------------------------------------------------------------------
// SIR RK4 step - shared definitions
// Formats, register codes, reset values and saturation helpers for the
// SIR fourth-order Runge-Kutta stepper.
// -----------------------------------------------------------------------------
`default_nettype none

package sirk_pkg;

  // Number formats
  localparam int POP_W         = 48;   // signed populations, POP_FRAC_BITS fraction bits
  localparam int POP_FRAC_BITS = 32;
  localparam int RATE_W        = 32;   // unsigned Q0.32
  localparam int RATE_FRAC     = 32;
  localparam int STEP_W        = 32;   // unsigned Q8.24
  localparam int STEP_FRAC     = 24;
  localparam int TIME_W        = 40;   // unsigned, STEP_FRAC fraction bits
  localparam int OFFS_W        = 8;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_INFECTION_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SUS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_INF       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_REC       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT     = 3'd7;

  // Register reset values
  localparam logic [RATE_W-1:0] INFECTION_RATE_RST = 32'd4294967;
  localparam logic [RATE_W-1:0] RECOVERY_RATE_RST  = 32'd429496730;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST      = 32'd16777216;
  localparam logic [POP_W-1:0]  INIT_SUS_RST       = 48'd2147483648000;
  localparam logic [POP_W-1:0]  INIT_INF_RST       = 48'd4294967296;
  localparam logic [POP_W-1:0]  INIT_REC_RST       = 48'd0;
  localparam logic [OFFS_W-1:0] TIME_OFFSET_RST    = 8'd0;
  localparam logic [TIME_W-1:0] TIME_LIMIT_RST     = 40'd1677721600;

  // Datapath widths
  localparam int SUM_W     = POP_W + 3;          // d1 + 2*d2 + 2*d3 + d4
  localparam int AMAG_W    = SUM_W - 1;          // magnitude of multiplicand
  localparam int DIG_W     = 16;                 // multiplier digit
  localparam int NDIG      = 3;
  localparam int BMAG_W    = DIG_W * NDIG;       // magnitude of multiplier
  localparam int ACC_W     = AMAG_W + BMAG_W;
  localparam int CLAMP_BIT = 62;                 // products clamp at 2^62
  localparam int RES_W     = CLAMP_BIT + 1;
  localparam int DIV_W     = 64;
  localparam int DIV_STEP  = 8;                  // quotient bits per cycle
  localparam int DIV_CYC   = DIV_W / DIV_STEP;
  localparam logic [3:0] DIVISOR = 4'd6;

  typedef logic signed [POP_W-1:0] pop_t;

  localparam pop_t POP_MAX = pop_t'({1'b0, {(POP_W-1){1'b1}}});
  localparam pop_t POP_MIN = pop_t'({1'b1, {(POP_W-1){1'b0}}});

  typedef enum logic [2:0] {
    OP_BS,    // b * S
    OP_BSI,   // (b * S) * I
    OP_GI,    // g * I
    OP_INC,   // stage increment d * h / 2, or d * h at the full step
    OP_FIN    // final increment sum * h / 6
  } op_e;

  typedef struct packed {
    pop_t val;
    logic ovf;
  } sat_t;

  // Apply a sign to a clamped magnitude and saturate to the population range.
  function automatic sat_t sat_mag(input logic neg, input logic [RES_W-1:0] mag);
    sat_t r;
    logic hi_set;
    hi_set = |mag[RES_W-1:POP_W];
    if (neg) begin
      r.ovf = hi_set || (mag[POP_W-1] && (|mag[POP_W-2:0]));
      r.val = r.ovf ? POP_MIN : pop_t'(-mag[POP_W-1:0]);
    end else begin
      r.ovf = hi_set || mag[POP_W-1];
      r.val = r.ovf ? POP_MAX : pop_t'(mag[POP_W-1:0]);
    end
    return r;
  endfunction

  // Saturate a one-bit-grown sum to the population range.
  function automatic sat_t sat_grow(input logic signed [POP_W:0] v);
    sat_t r;
    r.ovf = v[POP_W] ^ v[POP_W-1];
    if (r.ovf) begin
      r.val = v[POP_W] ? POP_MIN : POP_MAX;
    end else begin
      r.val = pop_t'(v[POP_W-1:0]);
    end
    return r;
  endfunction

  // Initial population from an unsigned register.
  function automatic sat_t load_init(input logic [POP_W-1:0] v);
    sat_t r;
    r.ovf = v[POP_W-1];
    r.val = r.ovf ? POP_MAX : pop_t'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sir_rk4_step.sv =====
// -----------------------------------------------------------------------------
// SIR RK4 step
// Advances S, I, R one fourth-order Runge-Kutta step per input transfer
// using one shared multiply unit and a divide-by-six unit.
// -----------------------------------------------------------------------------
// Each accepted input item advances the susceptible, infected and recovered
// populations by one step h and produces one result: the time before the
// step (plus the whole-number offset), the new populations, a last flag once
// elapsed time plus h reaches the time limit, and an overflow flag when any
// value saturated. restart_i reloads the populations from the initial
// registers and zeroes the elapsed time first. All products go through one
// 50x16-bit multiplier that accumulates two or three 16-bit digits per
// product; the final increments are divided by six eight quotient bits per
// cycle. The input stalls from an item's transfer until its result is loaded
// into the output register, so no new item is taken while one is in flight.
// The result register lets the next item start while a result is pending.
// Configuration registers may only be written while no item is in flight.
`default_nettype none

module sir_rk4_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sirk_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sirk_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  restart_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sirk_pkg::TIME_W-1:0]           time_stamp_o,
  output logic signed [sirk_pkg::POP_W-1:0]     out_susceptible_o,
  output logic signed [sirk_pkg::POP_W-1:0]     out_infected_o,
  output logic signed [sirk_pkg::POP_W-1:0]     out_recovered_o,
  output logic                                  last_o,
  output logic                                  overflow_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ISSUE = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_WB    = 4'd4;
  localparam logic [3:0] S_DERIV = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FWB   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [1:0] STG_FIRST = 2'd0;
  localparam logic [1:0] STG_FULL  = 2'd2;   // third derivative point, full step
  localparam logic [1:0] STG_FINAL = 2'd3;

  localparam logic [1:0] LANE_S = 2'd0;
  localparam logic [1:0] LANE_I = 2'd1;
  localparam logic [1:0] LANE_R = 2'd2;

  // Configuration registers
  logic [sirk_pkg::RATE_W-1:0] infection_rate_q;
  logic [sirk_pkg::RATE_W-1:0] recovery_rate_q;
  logic [sirk_pkg::STEP_W-1:0] step_size_q;
  logic [sirk_pkg::POP_W-1:0]  init_sus_q;
  logic [sirk_pkg::POP_W-1:0]  init_inf_q;
  logic [sirk_pkg::POP_W-1:0]  init_rec_q;
  logic [sirk_pkg::OFFS_W-1:0] time_offset_q;
  logic [sirk_pkg::TIME_W-1:0] time_limit_q;

  // Sequencer
  logic [3:0]      state_q, state_d;
  sirk_pkg::op_e   op_q, op_d;
  logic [1:0]      lane_q, lane_d;
  logic [1:0]      stage_q, stage_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            ovf_q, ovf_d;

  // Model state and intermediates
  sirk_pkg::pop_t              pop_q [3];
  sirk_pkg::pop_t              pop_d [3];
  logic [sirk_pkg::TIME_W-1:0] elapsed_q, elapsed_d;
  sirk_pkg::pop_t              p_q [3];
  sirk_pkg::pop_t              p_d [3];
  sirk_pkg::pop_t              drv_q [3];
  sirk_pkg::pop_t              drv_d [3];
  logic signed [sirk_pkg::SUM_W-1:0] sum_q [3];
  logic signed [sirk_pkg::SUM_W-1:0] sum_d [3];
  sirk_pkg::pop_t              bs_q, bs_d;
  sirk_pkg::pop_t              bsi_q, bsi_d;
  sirk_pkg::pop_t              gi_q, gi_d;

  // Multiply unit
  logic [sirk_pkg::AMAG_W-1:0] a_mag_q, a_mag_d;
  logic [sirk_pkg::BMAG_W-1:0] b_sh_q, b_sh_d;
  logic                        neg_q, neg_d;
  logic [sirk_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [sirk_pkg::RES_W-1:0]  res_q, res_d;

  // Divide-by-six unit
  logic [sirk_pkg::DIV_W-1:0]  num_q, num_d;
  logic [sirk_pkg::DIV_W-1:0]  quo_q, quo_d;
  logic [2:0]                  rem_q, rem_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [sirk_pkg::TIME_W-1:0] stamp_q, stamp_d;
  sirk_pkg::pop_t              out_pop_q [3];
  sirk_pkg::pop_t              out_pop_d [3];
  logic                        last_q, last_d;
  logic                        out_ovf_q, out_ovf_d;

  // Operand selection
  logic signed [sirk_pkg::SUM_W-1:0] opa;
  logic signed [sirk_pkg::SUM_W-1:0] a_abs;
  logic                              opb_neg;
  logic [sirk_pkg::BMAG_W-1:0]       opb_mag;
  logic                              opb_wide;

  always_comb begin
    opa      = '0;
    opb_neg  = 1'b0;
    opb_mag  = '0;
    opb_wide = 1'b0;
    unique case (op_q)
      sirk_pkg::OP_BS: begin
        opa     = {{(sirk_pkg::SUM_W-sirk_pkg::POP_W){p_q[LANE_S][sirk_pkg::POP_W-1]}},
                   p_q[LANE_S]};
        opb_mag = sirk_pkg::BMAG_W'(infection_rate_q);
      end
      sirk_pkg::OP_BSI: begin
        opa      = {{(sirk_pkg::SUM_W-sirk_pkg::POP_W){bs_q[sirk_pkg::POP_W-1]}}, bs_q};
        opb_neg  = p_q[LANE_I][sirk_pkg::POP_W-1];
        opb_mag  = opb_neg ? sirk_pkg::BMAG_W'(-p_q[LANE_I]) :
                             sirk_pkg::BMAG_W'(p_q[LANE_I]);
        opb_wide = 1'b1;
      end
      sirk_pkg::OP_GI: begin
        opa     = {{(sirk_pkg::SUM_W-sirk_pkg::POP_W){p_q[LANE_I][sirk_pkg::POP_W-1]}},
                   p_q[LANE_I]};
        opb_mag = sirk_pkg::BMAG_W'(recovery_rate_q);
      end
      sirk_pkg::OP_INC: begin
        opa     = {{(sirk_pkg::SUM_W-sirk_pkg::POP_W){drv_q[lane_q][sirk_pkg::POP_W-1]}},
                   drv_q[lane_q]};
        opb_mag = sirk_pkg::BMAG_W'(step_size_q);
      end
      sirk_pkg::OP_FIN: begin
        opa     = sum_q[lane_q];
        opb_mag = sirk_pkg::BMAG_W'(step_size_q);
      end
      default: begin
        opa = '0;
      end
    endcase
    a_abs = opa[sirk_pkg::SUM_W-1] ? -opa : opa;
  end

  // Digit product, shift-and-clamp, saturation and division helpers
  logic [sirk_pkg::AMAG_W+sirk_pkg::DIG_W-1:0] prod;
  logic [sirk_pkg::ACC_W-1:0]  shifted;
  logic                        clamp;
  sirk_pkg::sat_t              wb_val;
  sirk_pkg::sat_t              fin_val;
  sirk_pkg::sat_t              lane_new;
  sirk_pkg::sat_t              fin_new;
  sirk_pkg::sat_t              ld [3];
  sirk_pkg::sat_t              drv_s, drv_i;
  logic signed [sirk_pkg::POP_W:0] lane_sum, fin_sum;
  logic [2:0]                  div_rem;
  logic [3:0]                  div_t;
  logic [sirk_pkg::DIV_STEP-1:0] div_q;
  logic [sirk_pkg::TIME_W:0]   stamp_sum, next_sum;
  logic                        out_free;
  logic                        dbl;

  always_comb begin
    prod = a_mag_q * b_sh_q[sirk_pkg::BMAG_W-1 -: sirk_pkg::DIG_W];

    unique case (op_q)
      sirk_pkg::OP_BSI: shifted = acc_q >> sirk_pkg::POP_FRAC_BITS;
      sirk_pkg::OP_INC: shifted = (stage_q == STG_FULL) ? (acc_q >> sirk_pkg::STEP_FRAC) :
                                  (acc_q >> (sirk_pkg::STEP_FRAC + 1));
      sirk_pkg::OP_FIN: shifted = acc_q >> sirk_pkg::STEP_FRAC;
      default:          shifted = acc_q >> sirk_pkg::RATE_FRAC;
    endcase
    clamp = (|shifted[sirk_pkg::ACC_W-1:sirk_pkg::RES_W]) ||
            (shifted[sirk_pkg::RES_W-1] && (|shifted[sirk_pkg::RES_W-2:0]));

    wb_val   = sirk_pkg::sat_mag(neg_q, res_q);
    lane_sum = {pop_q[lane_q][sirk_pkg::POP_W-1], pop_q[lane_q]} +
               {wb_val.val[sirk_pkg::POP_W-1], wb_val.val};
    lane_new = sirk_pkg::sat_grow(lane_sum);

    fin_val  = sirk_pkg::sat_mag(neg_q, quo_q[sirk_pkg::RES_W-1:0]);
    fin_sum  = {pop_q[lane_q][sirk_pkg::POP_W-1], pop_q[lane_q]} +
               {fin_val.val[sirk_pkg::POP_W-1], fin_val.val};
    fin_new  = sirk_pkg::sat_grow(fin_sum);

    ld[LANE_S] = sirk_pkg::load_init(init_sus_q);
    ld[LANE_I] = sirk_pkg::load_init(init_inf_q);
    ld[LANE_R] = sirk_pkg::load_init(init_rec_q);

    drv_s = sirk_pkg::sat_grow(-{bsi_q[sirk_pkg::POP_W-1], bsi_q});
    drv_i = sirk_pkg::sat_grow({bsi_q[sirk_pkg::POP_W-1], bsi_q} -
                               {gi_q[sirk_pkg::POP_W-1], gi_q});

    // Restoring division by six, one quotient bit per step
    div_rem = rem_q;
    div_q   = '0;
    for (int k = 0; k < sirk_pkg::DIV_STEP; k++) begin
      div_t = {div_rem, num_q[sirk_pkg::DIV_W-1-k]};
      if (div_t >= sirk_pkg::DIVISOR) begin
        div_q[sirk_pkg::DIV_STEP-1-k] = 1'b1;
        div_t = div_t - sirk_pkg::DIVISOR;
      end
      div_rem = div_t[2:0];
    end

    stamp_sum = {1'b0, elapsed_q} +
                ((sirk_pkg::TIME_W+1)'(time_offset_q) << sirk_pkg::STEP_FRAC);
    next_sum  = {1'b0, elapsed_q} + (sirk_pkg::TIME_W+1)'(step_size_q);
    out_free  = !out_valid_q || !out_stall_i;
    dbl       = (stage_q != STG_FIRST) && (stage_q != STG_FINAL);
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    lane_d      = lane_q;
    stage_d     = stage_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    elapsed_d   = elapsed_q;
    bs_d        = bs_q;
    bsi_d       = bsi_q;
    gi_d        = gi_q;
    a_mag_d     = a_mag_q;
    b_sh_d      = b_sh_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    res_d       = res_q;
    num_d       = num_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    stamp_d     = stamp_q;
    last_d      = last_q;
    out_ovf_d   = out_ovf_q;
    for (int i = 0; i < 3; i++) begin
      pop_d[i]     = pop_q[i];
      p_d[i]       = p_q[i];
      drv_d[i]     = drv_q[i];
      sum_d[i]     = sum_q[i];
      out_pop_d[i] = out_pop_q[i];
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ovf_d = 1'b0;
          for (int i = 0; i < 3; i++) begin
            if (restart_i) begin
              pop_d[i] = ld[i].val;
              p_d[i]   = ld[i].val;
              ovf_d    = ovf_d | ld[i].ovf;
            end else begin
              p_d[i] = pop_q[i];
            end
            sum_d[i] = '0;
          end
          if (restart_i) begin
            elapsed_d = '0;
          end
          stage_d = STG_FIRST;
          op_d    = sirk_pkg::OP_BS;
          lane_d  = LANE_S;
          state_d = S_ISSUE;
        end
      end

      S_ISSUE: begin
        a_mag_d = a_abs[sirk_pkg::AMAG_W-1:0];
        b_sh_d  = opb_wide ? opb_mag : (opb_mag << sirk_pkg::DIG_W);
        cnt_d   = opb_wide ? 3'(sirk_pkg::NDIG - 1) : 3'(sirk_pkg::NDIG - 2);
        neg_d   = opa[sirk_pkg::SUM_W-1] ^ opb_neg;
        acc_d   = '0;
        state_d = S_MUL;
      end

      S_MUL: begin
        // most significant digit first
        acc_d  = (acc_q << sirk_pkg::DIG_W) + sirk_pkg::ACC_W'(prod);
        b_sh_d = b_sh_q << sirk_pkg::DIG_W;
        if (cnt_q == 3'd0) begin
          state_d = S_SHIFT;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end

      S_SHIFT: begin
        res_d = clamp ? {1'b1, {(sirk_pkg::RES_W-1){1'b0}}} :
                        shifted[sirk_pkg::RES_W-1:0];
        ovf_d = ovf_q | clamp;
        num_d = {1'b0, res_d};
        quo_d = '0;
        rem_d = '0;
        cnt_d = 3'(sirk_pkg::DIV_CYC - 1);
        state_d = (op_q == sirk_pkg::OP_FIN) ? S_DIV : S_WB;
      end

      S_WB: begin
        ovf_d   = ovf_q | wb_val.ovf;
        state_d = S_ISSUE;
        unique case (op_q)
          sirk_pkg::OP_BS: begin
            bs_d = wb_val.val;
            op_d = sirk_pkg::OP_BSI;
          end
          sirk_pkg::OP_BSI: begin
            bsi_d = wb_val.val;
            op_d  = sirk_pkg::OP_GI;
          end
          sirk_pkg::OP_GI: begin
            gi_d    = wb_val.val;
            state_d = S_DERIV;
          end
          sirk_pkg::OP_INC: begin
            p_d[lane_q] = lane_new.val;
            ovf_d       = ovf_q | wb_val.ovf | lane_new.ovf;
            if (lane_q == LANE_R) begin
              lane_d  = LANE_S;
              stage_d = stage_q + 2'd1;
              op_d    = sirk_pkg::OP_BS;
            end else begin
              lane_d = lane_q + 2'd1;
            end
          end
          default: begin
            state_d = S_ISSUE;
          end
        endcase
      end

      S_DERIV: begin
        drv_d[LANE_S] = drv_s.val;
        drv_d[LANE_I] = drv_i.val;
        drv_d[LANE_R] = gi_q;
        ovf_d         = ovf_q | drv_s.ovf | drv_i.ovf;
        state_d       = S_ACC;
      end

      S_ACC: begin
        // weights 1, 2, 2, 1 over the four stages
        for (int i = 0; i < 3; i++) begin
          if (dbl) begin
            sum_d[i] = sum_q[i] +
                       {{(sirk_pkg::SUM_W-sirk_pkg::POP_W-1){drv_q[i][sirk_pkg::POP_W-1]}},
                        drv_q[i], 1'b0};
          end else begin
            sum_d[i] = sum_q[i] +
                       {{(sirk_pkg::SUM_W-sirk_pkg::POP_W){drv_q[i][sirk_pkg::POP_W-1]}},
                        drv_q[i]};
          end
        end
        op_d    = (stage_q == STG_FINAL) ? sirk_pkg::OP_FIN : sirk_pkg::OP_INC;
        lane_d  = LANE_S;
        state_d = S_ISSUE;
      end

      S_DIV: begin
        num_d = num_q << sirk_pkg::DIV_STEP;
        quo_d = {quo_q[sirk_pkg::DIV_W-sirk_pkg::DIV_STEP-1:0], div_q};
        rem_d = div_rem;
        if (cnt_q == 3'd0) begin
          state_d = S_FWB;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end

      S_FWB: begin
        pop_d[lane_q] = fin_new.val;
        ovf_d         = ovf_q | fin_val.ovf | fin_new.ovf;
        if (lane_q == LANE_R) begin
          state_d = S_OUT;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_ISSUE;
        end
      end

      S_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          stamp_d     = stamp_sum[sirk_pkg::TIME_W] ? '1 : stamp_sum[sirk_pkg::TIME_W-1:0];
          last_d      = next_sum >= {1'b0, time_limit_q};
          out_ovf_d   = ovf_q | stamp_sum[sirk_pkg::TIME_W] | next_sum[sirk_pkg::TIME_W];
          elapsed_d   = next_sum[sirk_pkg::TIME_W] ? '1 : next_sum[sirk_pkg::TIME_W-1:0];
          for (int i = 0; i < 3; i++) begin
            out_pop_d[i] = pop_q[i];
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      op_q             <= sirk_pkg::OP_BS;
      lane_q           <= LANE_S;
      stage_q          <= STG_FIRST;
      cnt_q            <= '0;
      ovf_q            <= 1'b0;
      out_valid_q      <= 1'b0;
      elapsed_q        <= '0;
      pop_q[LANE_S]    <= sirk_pkg::pop_t'(sirk_pkg::INIT_SUS_RST);
      pop_q[LANE_I]    <= sirk_pkg::pop_t'(sirk_pkg::INIT_INF_RST);
      pop_q[LANE_R]    <= sirk_pkg::pop_t'(sirk_pkg::INIT_REC_RST);
      infection_rate_q <= sirk_pkg::INFECTION_RATE_RST;
      recovery_rate_q  <= sirk_pkg::RECOVERY_RATE_RST;
      step_size_q      <= sirk_pkg::STEP_SIZE_RST;
      init_sus_q       <= sirk_pkg::INIT_SUS_RST;
      init_inf_q       <= sirk_pkg::INIT_INF_RST;
      init_rec_q       <= sirk_pkg::INIT_REC_RST;
      time_offset_q    <= sirk_pkg::TIME_OFFSET_RST;
      time_limit_q     <= sirk_pkg::TIME_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      lane_q      <= lane_d;
      stage_q     <= stage_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      elapsed_q   <= elapsed_d;
      for (int i = 0; i < 3; i++) begin
        pop_q[i] <= pop_d[i];
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sirk_pkg::CFG_INFECTION_RATE: infection_rate_q <= cfg_data_i[sirk_pkg::RATE_W-1:0];
          sirk_pkg::CFG_RECOVERY_RATE:  recovery_rate_q  <= cfg_data_i[sirk_pkg::RATE_W-1:0];
          sirk_pkg::CFG_STEP_SIZE:      step_size_q      <= cfg_data_i[sirk_pkg::STEP_W-1:0];
          sirk_pkg::CFG_INIT_SUS:       init_sus_q       <= cfg_data_i[sirk_pkg::POP_W-1:0];
          sirk_pkg::CFG_INIT_INF:       init_inf_q       <= cfg_data_i[sirk_pkg::POP_W-1:0];
          sirk_pkg::CFG_INIT_REC:       init_rec_q       <= cfg_data_i[sirk_pkg::POP_W-1:0];
          sirk_pkg::CFG_TIME_OFFSET:    time_offset_q    <= cfg_data_i[sirk_pkg::OFFS_W-1:0];
          sirk_pkg::CFG_TIME_LIMIT:     time_limit_q     <= cfg_data_i[sirk_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    bs_q      <= bs_d;
    bsi_q     <= bsi_d;
    gi_q      <= gi_d;
    a_mag_q   <= a_mag_d;
    b_sh_q    <= b_sh_d;
    neg_q     <= neg_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    num_q     <= num_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    stamp_q   <= stamp_d;
    last_q    <= last_d;
    out_ovf_q <= out_ovf_d;
    for (int i = 0; i < 3; i++) begin
      p_q[i]       <= p_d[i];
      drv_q[i]     <= drv_d[i];
      sum_q[i]     <= sum_d[i];
      out_pop_q[i] <= out_pop_d[i];
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign time_stamp_o      = stamp_q;
  assign out_susceptible_o = out_pop_q[LANE_S];
  assign out_infected_o    = out_pop_q[LANE_I];
  assign out_recovered_o   = out_pop_q[LANE_R];
  assign last_o            = last_q;
  assign overflow_o        = out_ovf_q;

endmodule

`default_nettype wire
